/* hw/rtl/stag_pkg.sv */
// ----------------------------------------------------------------------------
// stag_pkg
// Shared types and constants of the strided tensor address generator.
// ----------------------------------------------------------------------------
package stag_pkg;

    localparam int IDX_W  = 32;
    localparam int DIM_W  = 16;
    localparam int ADDR_W = 34;
    localparam int CNT_W  = 3 * DIM_W;
    localparam int PROD_W = 2 * DIM_W;

    typedef enum logic [2:0] {
        REG_RANK          = 3'd0,
        REG_SIZE_OUTER    = 3'd1,
        REG_SIZE_MIDDLE   = 3'd2,
        REG_SIZE_INNER    = 3'd3,
        REG_STRIDE_OUTER  = 3'd4,
        REG_STRIDE_MIDDLE = 3'd5,
        REG_STRIDE_INNER  = 3'd6,
        REG_BASE_OFFSET   = 3'd7
    } stag_reg_t;

    // side data carried alongside a division
    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic [DIM_W-1:0] c_inner;
    } stag_side_t;

    // one division step word: partial remainder, shifting numerator/quotient
    typedef struct packed {
        logic [DIM_W-1:0] rem;
        logic [IDX_W-1:0] num;
        stag_side_t       side;
    } stag_div_t;

endpackage

/* hw/rtl/stag_div_stage.sv */
// ----------------------------------------------------------------------------
// stag_div_stage
// One restoring division step: one quotient bit per register stage.
// ----------------------------------------------------------------------------
module stag_div_stage
    import stag_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic [DIM_W-1:0] divisor,
    input  logic             valid_in,
    input  stag_div_t        word_in,
    output logic             valid_out,
    output stag_div_t        word_out
);

    logic [DIM_W:0] trial;
    logic [DIM_W:0] diff;
    logic           ge;
    logic           valid_reg;
    stag_div_t      word_reg;
    stag_div_t      word_next;

    always_comb
    begin
        trial = {word_in.rem, word_in.num[IDX_W-1]};
        diff  = trial - {1'b0, divisor};
        ge    = (trial >= {1'b0, divisor});
        word_next      = word_in;
        word_next.rem  = ge ? diff[DIM_W-1:0] : trial[DIM_W-1:0];
        word_next.num  = {word_in.num[IDX_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            word_reg <= word_next;
        end
    end

    assign valid_out = valid_reg;
    assign word_out  = word_reg;

endmodule

/* hw/rtl/stag_divider.sv */
// ----------------------------------------------------------------------------
// stag_divider
// Pipelined 32 by 16 bit divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module stag_divider
    import stag_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic [DIM_W-1:0] divisor,
    input  logic             valid_in,
    input  stag_div_t        word_in,
    output logic             valid_out,
    output stag_div_t        word_out
);

    logic      valid_chain [IDX_W+1];
    stag_div_t word_chain  [IDX_W+1];

    assign valid_chain[0] = valid_in;
    assign word_chain[0]  = word_in;

    for (genvar i = 0; i < IDX_W; i++)
    begin : g_step
        stag_div_stage u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .divisor   (divisor),
            .valid_in  (valid_chain[i]),
            .word_in   (word_chain[i]),
            .valid_out (valid_chain[i+1]),
            .word_out  (word_chain[i+1])
        );
    end

    assign valid_out = valid_chain[IDX_W];
    assign word_out  = word_chain[IDX_W];

endmodule

/* hw/rtl/stag_mac.sv */
// ----------------------------------------------------------------------------
// stag_mac
// Coordinate times stride products, address sum and bounds check.
// ----------------------------------------------------------------------------
module stag_mac
    import stag_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              valid_in,
    input  logic [IDX_W-1:0]  idx,
    input  logic [DIM_W-1:0]  c_outer,
    input  logic [DIM_W-1:0]  c_middle,
    input  logic [DIM_W-1:0]  c_inner,
    input  logic [DIM_W-1:0]  st_outer,
    input  logic [DIM_W-1:0]  st_middle,
    input  logic [DIM_W-1:0]  st_inner,
    input  logic [IDX_W-1:0]  base,
    input  logic [CNT_W-1:0]  count,
    output logic              valid_out,
    output logic [ADDR_W-1:0] addr_out,
    output logic              oob_out
);

    logic              pv_reg;
    logic [PROD_W-1:0] po_reg;
    logic [PROD_W-1:0] pm_reg;
    logic [PROD_W-1:0] pi_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic              ov_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic              oob_reg;
    logic [ADDR_W-1:0] addr_next;
    logic              oob_next;

    always_comb
    begin
        oob_next  = ({{(CNT_W-IDX_W){1'b0}}, idx_reg} >= count);
        addr_next = {{(ADDR_W-IDX_W){1'b0}}, base}
                  + {{(ADDR_W-PROD_W){1'b0}}, po_reg}
                  + {{(ADDR_W-PROD_W){1'b0}}, pm_reg}
                  + {{(ADDR_W-PROD_W){1'b0}}, pi_reg};
        if (oob_next)
        begin
            addr_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else if (en)
        begin
            pv_reg <= valid_in;
            ov_reg <= pv_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            po_reg   <= c_outer * st_outer;
            pm_reg   <= c_middle * st_middle;
            pi_reg   <= c_inner * st_inner;
            idx_reg  <= idx;
            addr_reg <= addr_next;
            oob_reg  <= oob_next;
        end
    end

    assign valid_out = ov_reg;
    assign addr_out  = addr_reg;
    assign oob_out   = oob_reg;

endmodule

/* hw/rtl/strided_tensor_address_generator.sv */
// ----------------------------------------------------------------------------
// strided_tensor_address_generator
// Maps a row-major linear element index of a strided view to its address.
//
// Configuration: write cfg_index/cfg_data with cfg_valid; cfg_ready is
// always high. Write only while no words are in flight.
// Input: elem_index with in_valid, taken when in_stall is low.
// Output: physical_address and out_of_bounds with out_valid, taken when
// out_stall is low. One result word per input word, in order.
// Throughput: one word per cycle while out_stall does not hold the output.
// The path runs through two 32-stage bit-per-stage dividers (inner then
// middle size) and two stages of multiply and sum.
// The pipeline advances as a whole; while out_valid is held by out_stall
// every stage freezes and in_stall is raised.
// Reset: pipeline empties, registers take rank 0, sizes 1, strides 0
// (inner stride 1), base 0. After a configuration write the element count
// is rebuilt in cnt_p_reg (inner times middle size), then in count_reg.
// ----------------------------------------------------------------------------
module strided_tensor_address_generator
    import stag_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [2:0]        cfg_index,
    input  logic [31:0]       cfg_data,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [IDX_W-1:0]  elem_index,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [ADDR_W-1:0] physical_address,
    output logic              out_of_bounds
);

    logic [1:0]        rank_reg;
    logic [DIM_W-1:0]  so_reg, sm_reg, si_reg;
    logic [DIM_W-1:0]  to_reg, tm_reg, ti_reg;
    logic [IDX_W-1:0]  base_reg;
    logic [PROD_W-1:0] cnt_p_reg;
    logic [CNT_W-1:0]  count_reg;

    logic [DIM_W-1:0]  so_e, sm_e, si_e, to_e, tm_e, ti_e;
    logic              en;
    logic              v1, v2;
    stag_div_t         w0, w1, w1b, w2;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rank_reg <= 2'd0;
            so_reg   <= 16'd1;
            sm_reg   <= 16'd1;
            si_reg   <= 16'd1;
            to_reg   <= 16'd0;
            tm_reg   <= 16'd0;
            ti_reg   <= 16'd1;
            base_reg <= 32'd0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (stag_reg_t'(cfg_index))
                REG_RANK:          rank_reg <= cfg_data[1:0];
                REG_SIZE_OUTER:    so_reg   <= cfg_data[DIM_W-1:0];
                REG_SIZE_MIDDLE:   sm_reg   <= cfg_data[DIM_W-1:0];
                REG_SIZE_INNER:    si_reg   <= cfg_data[DIM_W-1:0];
                REG_STRIDE_OUTER:  to_reg   <= cfg_data[DIM_W-1:0];
                REG_STRIDE_MIDDLE: tm_reg   <= cfg_data[DIM_W-1:0];
                REG_STRIDE_INNER:  ti_reg   <= cfg_data[DIM_W-1:0];
                REG_BASE_OFFSET:   base_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // dimensions outside the rank: size 1, stride 0
    always_comb
    begin
        so_e = (rank_reg >= 2'd3) ? so_reg : 16'd1;
        sm_e = (rank_reg >= 2'd2) ? sm_reg : 16'd1;
        si_e = (rank_reg >= 2'd1) ? si_reg : 16'd1;
        to_e = (rank_reg >= 2'd3) ? to_reg : 16'd0;
        tm_e = (rank_reg >= 2'd2) ? tm_reg : 16'd0;
        ti_e = (rank_reg >= 2'd1) ? ti_reg : 16'd0;
    end

    always_ff @(posedge clk)
    begin
        cnt_p_reg <= si_e * sm_e;
        count_reg <= cnt_p_reg * so_e;
    end

    assign en       = !(out_valid && out_stall);
    assign in_stall = !en;

    always_comb
    begin
        w0              = '0;
        w0.num          = elem_index;
        w0.side.idx     = elem_index;
        w1b             = w1;
        w1b.rem         = '0;
        w1b.side.c_inner = w1.rem;
    end

    stag_divider u_div_inner (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .divisor   (si_e),
        .valid_in  (in_valid),
        .word_in   (w0),
        .valid_out (v1),
        .word_out  (w1)
    );

    stag_divider u_div_middle (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .divisor   (sm_e),
        .valid_in  (v1),
        .word_in   (w1b),
        .valid_out (v2),
        .word_out  (w2)
    );

    stag_mac u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid_in  (v2),
        .idx       (w2.side.idx),
        .c_outer   (w2.num[DIM_W-1:0]),
        .c_middle  (w2.rem),
        .c_inner   (w2.side.c_inner),
        .st_outer  (to_e),
        .st_middle (tm_e),
        .st_inner  (ti_e),
        .base      (base_reg),
        .count     (count_reg),
        .valid_out (out_valid),
        .addr_out  (physical_address),
        .oob_out   (out_of_bounds)
    );

    a_oob_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_of_bounds) |-> (physical_address == '0))
        else $error("out of bounds word with nonzero address");

    a_stall_link: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall == (out_valid && out_stall))
        else $error("input stall does not follow output hold");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("configuration port not ready");

endmodule
